FILE: hw/rtl/sliding_window_key_counter_unit_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SLIDING_WINDOW_KEY_COUNTER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_KEY_COUNTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWKC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/swkc_pkg.sv
package swkc_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF     = 32;
    localparam int KEY_PORT_W       = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPD_KEY,
        ST_UPD_EVICT
    } state_t;

    typedef struct packed {
        logic khit;
        logic ffound;
        logic ehit;
    } scan_flags_t;

endpackage

FILE: hw/rtl/swkc_ram.sv
module swkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/swkc_scan.sv
module swkc_scan #(
    parameter int KEY_BITS = swkc_pkg::KEY_BITS_DEF,
    parameter int TA       = 7,
    parameter int CW       = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clr,
    input  logic                  issue,
    input  logic [TA-1:0]         issue_addr,
    input  logic [KEY_BITS-1:0]   rd_key,
    input  logic [CW-1:0]         rd_cnt,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [KEY_BITS-1:0]   ev_key,
    input  logic                  ev_en,
    output swkc_pkg::scan_flags_t flags,
    output logic [TA-1:0]         kslot,
    output logic [CW-1:0]         kcnt,
    output logic [TA-1:0]         fslot,
    output logic [TA-1:0]         eslot,
    output logic [CW-1:0]         ecnt
);

    logic                  tag_vld_reg;
    logic [TA-1:0]         tag_addr_reg;
    swkc_pkg::scan_flags_t flags_reg;
    swkc_pkg::scan_flags_t flags_next;
    logic [TA-1:0]         kslot_reg;
    logic [TA-1:0]         fslot_reg;
    logic [TA-1:0]         eslot_reg;
    logic [CW-1:0]         kcnt_reg;
    logic [CW-1:0]         ecnt_reg;
    logic                  entry_used;
    logic                  k_match;
    logic                  f_match;
    logic                  e_match;

    assign entry_used = (rd_cnt != '0);
    assign k_match = tag_vld_reg && entry_used && (rd_key == key) && !flags_reg.khit;
    assign f_match = tag_vld_reg && !entry_used && !flags_reg.ffound;
    assign e_match = tag_vld_reg && ev_en && entry_used && (rd_key == ev_key)
                     && !flags_reg.ehit;

    always_comb
    begin
        flags_next = flags_reg;
        if (clr)
        begin
            flags_next = '0;
        end
        else
        begin
            if (k_match)
            begin
                flags_next.khit = 1'b1;
            end
            if (f_match)
            begin
                flags_next.ffound = 1'b1;
            end
            if (e_match)
            begin
                flags_next.ehit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_vld_reg <= 1'b0;
            flags_reg   <= '0;
        end
        else
        begin
            tag_vld_reg <= issue;
            flags_reg   <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_addr_reg <= issue_addr;
        if (k_match)
        begin
            kslot_reg <= tag_addr_reg;
            kcnt_reg  <= rd_cnt;
        end
        if (f_match)
        begin
            fslot_reg <= tag_addr_reg;
        end
        if (e_match)
        begin
            eslot_reg <= tag_addr_reg;
            ecnt_reg  <= rd_cnt;
        end
    end

    assign flags = flags_reg;
    assign kslot = kslot_reg;
    assign kcnt  = kcnt_reg;
    assign fslot = fslot_reg;
    assign eslot = eslot_reg;
    assign ecnt  = ecnt_reg;

endmodule

FILE: hw/rtl/sliding_window_key_counter_unit.sv
// Each request inserts one key into a window of the last WINDOW_DEPTH keys and reports
// whether the key was already among them, plus the key pushed out once the window is full.
// A request is taken when start is high and busy is low; busy then stays high while one
// compare unit walks all WINDOW_DEPTH + 1 table entries, one per cycle through the table
// memory read port, waits in ST_DRAIN for the last read, and then does the table and
// window updates in ST_UPD_KEY and ST_UPD_EVICT.
// A new request can therefore be taken only once busy has fallen again.
// The result appears on the result ports for one cycle with done high, in the cycle when
// busy falls, and must be captured then because the block cannot be stalled.
// After reset the block clears all WINDOW_DEPTH + 1 table entries with busy high.
module sliding_window_key_counter_unit #(
    parameter int WINDOW_DEPTH = swkc_pkg::WINDOW_DEPTH_DEF,
    parameter int KEY_BITS     = swkc_pkg::KEY_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [swkc_pkg::KEY_PORT_W-1:0] key,
    output logic                            done,
    output logic                            status,
    output logic                            evicted_valid,
    output logic [swkc_pkg::KEY_PORT_W-1:0] evicted_key,
    output logic                            key_dropped
);

    localparam int TD      = WINDOW_DEPTH + 1;
    localparam int TA      = $clog2(TD);
    localparam int CW      = $clog2(TD + 1);
    localparam int WA      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int KeyWide = (KEY_BITS > swkc_pkg::KEY_PORT_W) ? KEY_BITS
                                                                : swkc_pkg::KEY_PORT_W;

    swkc_pkg::state_t state_reg;
    swkc_pkg::state_t state_next;

    logic [TA-1:0]        addr_reg;
    logic [TA-1:0]        addr_next;
    logic [WA-1:0]        wpos_reg;
    logic [WA-1:0]        wpos_next;
    logic                 full_reg;
    logic                 full_next;
    logic                 ev_en_reg;
    logic                 ev_en_next;
    logic [KEY_BITS-1:0]  key_reg;
    logic [KEY_BITS-1:0]  key_next;
    logic                 done_reg;
    logic                 done_next;
    logic                 status_reg;
    logic                 status_next;
    logic                 ev_valid_reg;
    logic                 ev_valid_next;
    logic [swkc_pkg::KEY_PORT_W-1:0] ev_key_reg;
    logic [swkc_pkg::KEY_PORT_W-1:0] ev_key_next;
    logic                 dropped_reg;
    logic                 dropped_next;

    logic                 accept;
    logic                 last_addr;
    logic                 tbl_we;
    logic [TA-1:0]        tbl_waddr;
    logic [KEY_BITS-1:0]  tbl_wkey;
    logic [CW-1:0]        tbl_wcnt;
    logic                 tbl_re;
    logic [KEY_BITS+CW-1:0] tbl_rdata;
    logic                 win_we;
    logic                 win_re;
    logic [KEY_BITS-1:0]  win_rdata;
    logic                 scan_clr;

    logic [KeyWide-1:0]   key_wide;
    logic [KeyWide-1:0]   ev_wide;
    logic [KEY_BITS-1:0]  key_in;
    logic                 same_key;
    logic                 drop_now;

    swkc_pkg::scan_flags_t flags;
    logic [TA-1:0]        kslot;
    logic [CW-1:0]        kcnt;
    logic [TA-1:0]        fslot;
    logic [TA-1:0]        eslot;
    logic [CW-1:0]        ecnt;

    assign key_wide  = KeyWide'(key);
    assign key_in    = key_wide[KEY_BITS-1:0];
    assign ev_wide   = KeyWide'(win_rdata);
    assign same_key  = (win_rdata == key_reg);
    assign accept    = start && (state_reg == swkc_pkg::ST_IDLE);
    assign last_addr = (addr_reg == TA'(TD - 1));
    assign drop_now  = ev_en_reg && (same_key ? (!flags.khit && flags.ffound)
                                              : (flags.ehit && (ecnt <= CW'(1))));

    swkc_ram #(
        .WIDTH(KEY_BITS + CW),
        .DEPTH(TD)
    ) u_table (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata({tbl_wkey, tbl_wcnt}),
        .re   (tbl_re),
        .raddr(addr_reg),
        .rdata(tbl_rdata)
    );

    swkc_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(WINDOW_DEPTH)
    ) u_window (
        .clk  (clk),
        .we   (win_we),
        .waddr(wpos_reg),
        .wdata(key_reg),
        .re   (win_re),
        .raddr(wpos_reg),
        .rdata(win_rdata)
    );

    swkc_scan #(
        .KEY_BITS(KEY_BITS),
        .TA      (TA),
        .CW      (CW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (scan_clr),
        .issue     (tbl_re),
        .issue_addr(addr_reg),
        .rd_key    (tbl_rdata[KEY_BITS+CW-1:CW]),
        .rd_cnt    (tbl_rdata[CW-1:0]),
        .key       (key_reg),
        .ev_key    (win_rdata),
        .ev_en     (ev_en_reg),
        .flags     (flags),
        .kslot     (kslot),
        .kcnt      (kcnt),
        .fslot     (fslot),
        .eslot     (eslot),
        .ecnt      (ecnt)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swkc_pkg::ST_CLEAR:
            begin
                if (last_addr)
                begin
                    state_next = swkc_pkg::ST_IDLE;
                end
            end
            swkc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = swkc_pkg::ST_SCAN;
                end
            end
            swkc_pkg::ST_SCAN:
            begin
                if (last_addr)
                begin
                    state_next = swkc_pkg::ST_DRAIN;
                end
            end
            swkc_pkg::ST_DRAIN:     state_next = swkc_pkg::ST_UPD_KEY;
            swkc_pkg::ST_UPD_KEY:   state_next = swkc_pkg::ST_UPD_EVICT;
            swkc_pkg::ST_UPD_EVICT: state_next = swkc_pkg::ST_IDLE;
            default:                state_next = swkc_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_waddr = addr_reg;
        tbl_wkey  = key_reg;
        tbl_wcnt  = '0;
        tbl_re    = 1'b0;
        win_we    = 1'b0;
        win_re    = 1'b0;
        scan_clr  = 1'b0;
        unique case (state_reg)
            swkc_pkg::ST_CLEAR:
            begin
                tbl_we = 1'b1;
            end
            swkc_pkg::ST_IDLE:
            begin
                win_re   = start;
                scan_clr = start;
            end
            swkc_pkg::ST_SCAN:
            begin
                tbl_re = 1'b1;
            end
            swkc_pkg::ST_DRAIN:
            begin
            end
            swkc_pkg::ST_UPD_KEY:
            begin
                win_we = 1'b1;
                if (!(ev_en_reg && same_key))
                begin
                    if (flags.khit)
                    begin
                        tbl_we    = 1'b1;
                        tbl_waddr = kslot;
                        tbl_wcnt  = kcnt + CW'(1);
                    end
                    else if (flags.ffound)
                    begin
                        tbl_we    = 1'b1;
                        tbl_waddr = fslot;
                        tbl_wcnt  = CW'(1);
                    end
                end
            end
            swkc_pkg::ST_UPD_EVICT:
            begin
                if (ev_en_reg && !same_key && flags.ehit)
                begin
                    tbl_we    = 1'b1;
                    tbl_waddr = eslot;
                    tbl_wkey  = win_rdata;
                    tbl_wcnt  = (ecnt <= CW'(1)) ? '0 : ecnt - CW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        addr_next     = addr_reg;
        wpos_next     = wpos_reg;
        full_next     = full_reg;
        ev_en_next    = ev_en_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        ev_valid_next = ev_valid_reg;
        ev_key_next   = ev_key_reg;
        dropped_next  = dropped_reg;
        if (state_reg == swkc_pkg::ST_CLEAR || state_reg == swkc_pkg::ST_SCAN)
        begin
            addr_next = last_addr ? '0 : addr_reg + TA'(1);
        end
        if (accept)
        begin
            key_next   = key_in;
            ev_en_next = full_reg;
        end
        if (state_reg == swkc_pkg::ST_UPD_KEY)
        begin
            if (wpos_reg == WA'(WINDOW_DEPTH - 1))
            begin
                wpos_next = '0;
                full_next = 1'b1;
            end
            else
            begin
                wpos_next = wpos_reg + WA'(1);
            end
        end
        if (state_reg == swkc_pkg::ST_UPD_EVICT)
        begin
            done_next     = 1'b1;
            status_next   = flags.khit;
            ev_valid_next = ev_en_reg;
            ev_key_next   = ev_en_reg ? ev_wide[swkc_pkg::KEY_PORT_W-1:0] : '0;
            dropped_next  = drop_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swkc_pkg::ST_CLEAR;
            addr_reg  <= '0;
            wpos_reg  <= '0;
            full_reg  <= 1'b0;
            ev_en_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            wpos_reg  <= wpos_next;
            full_reg  <= full_next;
            ev_en_reg <= ev_en_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        status_reg   <= status_next;
        ev_valid_reg <= ev_valid_next;
        ev_key_reg   <= ev_key_next;
        dropped_reg  <= dropped_next;
    end

    assign busy          = (state_reg != swkc_pkg::ST_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_key   = ev_key_reg;
    assign key_dropped   = dropped_reg;

endmodule

FILE: hw/rtl/swkc_checker.sv
`include "sliding_window_key_counter_unit_macros.svh"

module swkc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic                            evicted_valid,
    input logic [swkc_pkg::KEY_PORT_W-1:0] evicted_key,
    input logic                            key_dropped
);

    `SWKC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted request did not raise busy.")
    `SWKC_ASSERT_SAME(a_done_after_busy, done, !busy && $past(busy), "Result without request.")
    `SWKC_ASSERT_NEXT(a_done_single, done, !done, "Result strobe held for two cycles.")
    `SWKC_ASSERT_SAME(a_no_evict_clean, done && !evicted_valid,
                      evicted_key == '0 && !key_dropped, "Eviction fields set without eviction.")

endmodule

bind sliding_window_key_counter_unit swkc_checker u_swkc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .evicted_valid(evicted_valid),
    .evicted_key  (evicted_key),
    .key_dropped  (key_dropped)
);
